@@ rtl/hmvc_pkg.sv @@
package hmvc_pkg;

	localparam int ModeW    = 3;
	localparam int ValueW   = 32;
	localparam int DivCodeW = 2;
	localparam int ResultW  = 22;
	// operand width of the divider chain, one cell per quotient bit
	localparam int OpW      = 22;
	localparam int NumCells = OpW;

	localparam int InDataW  = 40;
	localparam int OutDataW = 24;

	typedef enum logic [ModeW-1:0] {
		MODE_VOLT_TO_CODE = 3'd0,
		MODE_CODE_TO_VOLT = 3'd1,
		MODE_RPM_TO_CODE  = 3'd2,
		MODE_CODE_TO_RPM  = 3'd3,
		MODE_TEMP_TO_CODE = 3'd4,
		MODE_CODE_TO_TEMP = 3'd5,
		MODE_DIV_TO_CODE  = 3'd6,
		MODE_CODE_TO_DIV  = 3'd7
	} mode_t;

	// what the output stage does with the quotient
	typedef enum logic [1:0] {
		POST_QUO = 2'd0,
		POST_NEG = 2'd1,
		POST_FAN = 2'd2,
		POST_BYP = 2'd3
	} post_t;

	typedef struct packed {
		logic [OpW-1:0]     rem;
		logic [OpW-1:0]     nq;    // numerator bits out, quotient bits in
		logic [OpW-1:0]     den;
		post_t              post;
		logic [ResultW-1:0] byp;
	} div_data_t;

	localparam logic [OpW-1:0] FAN_CLK     = 22'd1350000;
	localparam logic [OpW-1:0] DEN_TEN     = 22'd10;
	localparam logic [OpW-1:0] DEN_HUNDRED = 22'd100;

	// input thresholds where the clamped conversions saturate
	localparam logic signed [ValueW-1:0] VOLT_IN_MAX  = 32'sd408;
	localparam logic signed [ValueW-1:0] TEMP_IN_LOW  = 32'sd519;
	localparam logic signed [ValueW-1:0] TEMP_IN_HIGH = 32'sd2652;
	localparam logic [14:0]              TEMP_OFFSET  = 15'd6227;
	localparam logic signed [15:0]       TEMP_SCALE   = 16'sd83;
	localparam logic signed [15:0]       TEMP_BIAS    = 16'sd5212;

	localparam logic [ResultW-1:0] CODE_MAX = 22'd255;
	localparam logic [ResultW-1:0] FAN_MAX  = 22'd254;

endpackage

@@ rtl/hw_monitor_value_converter_unit.sv @@
// Path: an input transfer passes the operand stage, the 22 divider cells
//   and the result stage, each one registered, before its output transfer.
// Throughput: one transfer per cycle while the output side is ready; the
//   22-cell divider chain resolves one quotient bit per cell.
// Reset: arst_n clears every stage valid at once; no item survives reset.
module hw_monitor_value_converter_unit
	import hmvc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [InDataW-1:0]  s_axis_tdata,  // value[31:0], divider_code[33:32], pad
	input  logic [ModeW-1:0]    s_axis_tuser,  // mode[2:0]
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [OutDataW-1:0] m_axis_tdata   // converted[21:0], pad
);

	// link i feeds cell i; link NumCells feeds the result stage
	logic      link_valid [NumCells+1];
	logic      link_ready [NumCells+1];
	div_data_t link_data  [NumCells+1];

	logic [ResultW-1:0] converted;

	// Operand stage: picks numerator, divisor and post-op per mode.
	// Saturating, table and volt-to-code cases still pass the divider chain; their result rides along as byp.
	hmvc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.mode         (mode_t'(s_axis_tuser)),
		.value        (s_axis_tdata[ValueW-1:0]),
		.divider_code (s_axis_tdata[ValueW+DivCodeW-1:ValueW]),
		.out_valid    (link_valid[0]),
		.out_ready    (link_ready[0]),
		.out_data     (link_data[0])
	);

	// Divider chain: each cell shifts in one numerator bit, does one
	// compare/subtract and hands the partial result to its neighbor.
	// Each cell holds its item until the next one frees up, so bubbles
	// close up and input keeps flowing into empty cells while a result waits.
	for (genvar i = 0; i < NumCells; i++) begin : g_cell
		hmvc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (link_valid[i]),
			.in_ready  (link_ready[i]),
			.in_data   (link_data[i]),
			.out_valid (link_valid[i+1]),
			.out_ready (link_ready[i+1]),
			.out_data  (link_data[i+1])
		);
	end

	// Result stage: sign fix for negative temperatures, fan code clamp,
	// bypass select; its register is the output holding register.
	hmvc_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (link_valid[NumCells]),
		.in_ready  (link_ready[NumCells]),
		.in_data   (link_data[NumCells]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.converted (converted)
	);

	assign m_axis_tdata = {{(OutDataW-ResultW){1'b0}}, converted};

endmodule

@@ rtl/hmvc_front.sv @@
module hmvc_front
	import hmvc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  mode_t                    mode,
	input  logic signed [ValueW-1:0] value,
	input  logic [DivCodeW-1:0]      divider_code,
	output logic                     out_valid,
	input  logic                     out_ready,
	output div_data_t                out_data
);

	logic             valid_s1;
	div_data_t        data_s1;
	div_data_t        d;

	logic [7:0]         code;
	logic [12:0]        t0;
	logic [14:0]        n4;
	logic signed [15:0] s16;
	logic signed [15:0] n5;
	logic [15:0]        mag5;
	logic [24:0]        x25;
	logic               fan_big;
	logic [10:0]        x3;

	assign code    = value[7:0];
	assign t0      = 13'(value[8:0]) * 13'd10 + 13'd8;
	assign n4      = 15'(value[11:0]) * 15'd12 - TEMP_OFFSET;
	assign s16     = {{8{value[7]}}, value[7:0]};
	assign n5      = s16 * TEMP_SCALE + TEMP_BIAS;
	assign mag5    = n5[15] ? 16'(-n5) : 16'(n5);
	assign x25     = 25'(value[21:0]) << divider_code;
	// rpm times divider at or above 2^22 always rounds to quotient 0
	assign fan_big = (|value[30:22]) || (|x25[24:22]);
	assign x3      = 11'(code) << divider_code;

	always_comb begin
		d      = '0;
		d.den  = 22'd1;
		d.post = POST_BYP;
		case (mode)
			MODE_VOLT_TO_CODE: begin
				if (value[31]) begin
					d.byp = '0;
				end else if (value > VOLT_IN_MAX) begin
					d.byp = CODE_MAX;
				end else begin
					d.byp = 22'(t0[11:4]);
				end
			end
			MODE_CODE_TO_VOLT: begin
				d.nq   = 22'({code, 4'b0000}) + 22'd5;
				d.den  = DEN_TEN;
				d.post = POST_QUO;
			end
			MODE_RPM_TO_CODE: begin
				if (value[31] || value == '0) begin
					d.byp = CODE_MAX;
				end else if (fan_big) begin
					d.byp = 22'd1;
				end else begin
					d.nq   = FAN_CLK + 22'(x25[21:1]);
					d.den  = x25[21:0];
					d.post = POST_FAN;
				end
			end
			MODE_CODE_TO_RPM: begin
				if (code == 8'd0) begin
					d.byp = '1;
				end else if (code == 8'hFF) begin
					d.byp = '0;
				end else begin
					d.nq   = FAN_CLK;
					d.den  = 22'(x3);
					d.post = POST_QUO;
				end
			end
			MODE_TEMP_TO_CODE: begin
				if (value[31] || value < TEMP_IN_LOW) begin
					d.byp = '0;
				end else if (value > TEMP_IN_HIGH) begin
					d.byp = CODE_MAX;
				end else begin
					d.nq   = 22'(n4);
					d.den  = DEN_HUNDRED;
					d.post = POST_QUO;
				end
			end
			MODE_CODE_TO_TEMP: begin
				d.nq   = 22'(mag5);
				d.den  = DEN_TEN;
				d.post = n5[15] ? POST_NEG : POST_QUO;
			end
			MODE_DIV_TO_CODE: begin
				if (value == 32'sd8) begin
					d.byp = 22'd3;
				end else if (value == 32'sd4) begin
					d.byp = 22'd2;
				end else if (value == 32'sd1) begin
					d.byp = 22'd0;
				end else begin
					d.byp = 22'd1;
				end
			end
			MODE_CODE_TO_DIV: begin
				d.byp = 22'(4'b0001 << value[1:0]);
			end
			default: begin
				d.byp = '0;
			end
		endcase
	end

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_data  = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= d;
		end
	end

endmodule

@@ rtl/hmvc_cell.sv @@
module hmvc_cell
	import hmvc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  div_data_t in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output div_data_t out_data
);

	logic      valid_q;
	div_data_t data_q;
	div_data_t nxt;
	logic [OpW:0] trial;
	logic [OpW:0] diff;
	logic         ge;

	// one restoring step; rem < den keeps trial - den inside OpW+1 bits
	assign trial = {in_data.rem, in_data.nq[OpW-1]};
	assign diff  = trial - {1'b0, in_data.den};
	assign ge    = !diff[OpW];

	always_comb begin
		nxt     = in_data;
		nxt.rem = ge ? diff[OpW-1:0] : trial[OpW-1:0];
		nxt.nq  = {in_data.nq[OpW-2:0], ge};
	end

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= nxt;
		end
	end

endmodule

@@ rtl/hmvc_post.sv @@
module hmvc_post
	import hmvc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  div_data_t          in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [ResultW-1:0] converted
);

	logic               valid_q;
	logic [ResultW-1:0] result_q;
	logic [ResultW-1:0] res;
	logic [OpW-1:0]     q;

	assign q = in_data.nq;

	always_comb begin
		case (in_data.post)
			POST_QUO: res = ResultW'(q);
			POST_NEG: res = ResultW'(-q);
			POST_FAN: begin
				if (q == '0) begin
					res = 22'd1;
				end else if (q > FAN_MAX) begin
					res = FAN_MAX;
				end else begin
					res = ResultW'(q);
				end
			end
			POST_BYP: res = in_data.byp;
			default:  res = in_data.byp;
		endcase
	end

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign converted = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			result_q <= res;
		end
	end

endmodule

@@ rtl/hmvc_checker.sv @@
module hmvc_checker
	import hmvc_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_axis_tready,
	input logic                m_axis_tvalid,
	input logic                m_axis_tready,
	input logic [OutDataW-1:0] m_axis_tdata
);

	// an empty output register means the whole chain can take a transfer
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with output register empty");

	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ($signed(m_axis_tdata[ResultW-1:0]) >= -22'sd541 &&
			$signed(m_axis_tdata[ResultW-1:0]) <= 22'sd1350000))
		else $error("converted value out of range");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OutDataW-1:ResultW] == '0)
		else $error("output pad bits not zero");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled output transfer changed");

endmodule

bind hw_monitor_value_converter_unit hmvc_checker u_hmvc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
